[hdl/ipc_pkg.sv]
// shared types and constants for the input capture period collector
// no dependencies; imported by every module of the block
package ipc_pkg;

	localparam int MAX_PERIODS = 16;
	localparam int TICK_WIDTH  = 32;
	localparam int IDX_W       = $clog2(MAX_PERIODS);
	localparam int CNT_W       = $clog2(MAX_PERIODS + 1);

	localparam int TARGET_W  = 5;
	localparam int TIMEOUT_W = 16;

	localparam logic [TARGET_W-1:0]  TARGET_RESET  = TARGET_W'(16);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

	// register indexes of the configuration port
	localparam logic REG_PERIOD_TARGET = 1'b0;
	localparam logic REG_TIMEOUT       = 1'b1;

	// result kinds
	localparam logic KIND_PERIOD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_CAPTURE = 2'd1,
		CMD_OVERRUN = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_NOT_READY = 3'd2,
		ST_OVERRUN   = 3'd3,
		ST_TIMEOUT   = 3'd4
	} status_t;

	typedef struct packed {
		logic [TARGET_W-1:0]  period_target;
		logic [TIMEOUT_W-1:0] timeout_lim;
	} ipc_cfg_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      waddr;
		logic [TICK_WIDTH-1:0] wdata;
		logic                  re;
		logic [IDX_W-1:0]      raddr;
	} ipc_ram_req_t;

endpackage

[hdl/ipc_period_ram.sv]
// period store: one write port, one read port, registered read data
// depends on ipc_pkg
module ipc_period_ram
	import ipc_pkg::*;
(
	input  logic                  clk,
	input  ipc_ram_req_t          req,
	output logic [TICK_WIDTH-1:0] rdata
);

	logic [TICK_WIDTH-1:0] mem [MAX_PERIODS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

[hdl/ipc_ctrl.sv]
// run sequencer: command decode, period computation, store readout
// depends on ipc_pkg; drives the period store through ipc_ram_req_t
module ipc_ctrl
	import ipc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            cmd,
	input  logic [31:0]           capture_value,
	input  logic                  path_ready,
	input  ipc_cfg_t              cfg,
	output logic                  busy,
	output ipc_ram_req_t          ram_req,
	input  logic [TICK_WIDTH-1:0] ram_rdata,
	output logic                  result_strobe,
	output logic                  kind,
	output logic [31:0]           period_ticks,
	output logic [3:0]            period_slot,
	output logic [2:0]            status,
	output logic                  last_item
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	logic [TICK_WIDTH-1:0]  cap_q;
	logic                   ready_q;
	logic [TICK_WIDTH-1:0]  prev_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   base_q;
	logic                   capturing_q;
	logic [TIMEOUT_W-1:0]   elapsed_q;
	logic [CNT_W-1:0]       run_target_q;
	logic [TIMEOUT_W-1:0]   run_timeout_q;
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   stat_valid_q;
	status_t                stat_code_q;

	logic                   store_en;
	logic [CNT_W-1:0]       cnt_nxt;
	logic [TIMEOUT_W-1:0]   elapsed_nxt;
	logic                   cfg_bad;
	logic                   rd_more;

	assign busy = (state_q != S_IDLE);

	assign cfg_bad = (cfg.period_target == '0) ||
		(32'(cfg.period_target) > 32'(MAX_PERIODS)) || (cfg.timeout_lim == '0);

	assign store_en = (state_q == S_EXEC) && (cmd_q == CMD_CAPTURE) && capturing_q &&
		base_q && (cnt_q < run_target_q) && (32'(cnt_q) < 32'(MAX_PERIODS));
	assign cnt_nxt = store_en ? cnt_q + CNT_W'(1) : cnt_q;

	assign elapsed_nxt = (elapsed_q != '1) ? elapsed_q + TIMEOUT_W'(1) : elapsed_q;

	assign rd_more = (state_q == S_DUMP) && (rd_idx_q < cnt_q);

	always_comb begin
		ram_req.we    = store_en;
		ram_req.waddr = cnt_q[IDX_W-1:0];
		ram_req.wdata = cap_q - prev_q;
		ram_req.re    = rd_more;
		ram_req.raddr = rd_idx_q[IDX_W-1:0];
	end

	// period items come from the read stage, status items from the status register
	assign result_strobe = rd_valid_s1 | stat_valid_q;
	assign kind          = stat_valid_q ? KIND_STATUS : KIND_PERIOD;
	assign period_ticks  = rd_valid_s1 ? 32'(ram_rdata) : '0;
	assign period_slot   = rd_valid_s1 ? 4'(rd_idx_s1) : '0;
	assign status        = stat_valid_q ? stat_code_q : ST_OK;
	assign last_item     = stat_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= CMD_START;
			cap_q         <= '0;
			ready_q       <= 1'b0;
			prev_q        <= '0;
			cnt_q         <= '0;
			base_q        <= 1'b0;
			capturing_q   <= 1'b0;
			elapsed_q     <= '0;
			run_target_q  <= '0;
			run_timeout_q <= '0;
			rd_idx_q      <= '0;
			rd_valid_s1   <= 1'b0;
			rd_idx_s1     <= '0;
			stat_valid_q  <= 1'b0;
			stat_code_q   <= ST_OK;
		end else begin
			stat_valid_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_t'(cmd);
						cap_q   <= capture_value[TICK_WIDTH-1:0];
						ready_q <= path_ready;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					unique case (cmd_q)
						CMD_START: begin
							if (cfg_bad) begin
								stat_valid_q <= 1'b1;
								stat_code_q  <= ST_INVALID;
							end else if (!ready_q) begin
								stat_valid_q <= 1'b1;
								stat_code_q  <= ST_NOT_READY;
							end else begin
								prev_q        <= '0;
								cnt_q         <= '0;
								base_q        <= 1'b0;
								elapsed_q     <= '0;
								run_target_q  <= CNT_W'(cfg.period_target);
								run_timeout_q <= cfg.timeout_lim;
								capturing_q   <= 1'b1;
							end
						end
						CMD_CAPTURE: begin
							if (capturing_q) begin
								if (!base_q) begin
									prev_q <= cap_q;
									base_q <= 1'b1;
								end else begin
									if (store_en) begin
										prev_q <= cap_q;
									end
									cnt_q <= cnt_nxt;
									if (cnt_nxt >= run_target_q) begin
										capturing_q <= 1'b0;
										rd_idx_q    <= '0;
										state_q     <= S_DUMP;
									end
								end
							end
						end
						CMD_OVERRUN: begin
							if (capturing_q) begin
								capturing_q  <= 1'b0;
								stat_valid_q <= 1'b1;
								stat_code_q  <= ST_OVERRUN;
							end
						end
						CMD_TICK: begin
							if (capturing_q) begin
								elapsed_q <= elapsed_nxt;
								if (elapsed_nxt >= run_timeout_q) begin
									capturing_q  <= 1'b0;
									stat_valid_q <= 1'b1;
									stat_code_q  <= ST_TIMEOUT;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_DUMP: begin
					if (rd_more) begin
						rd_valid_s1 <= 1'b1;
						rd_idx_s1   <= rd_idx_q[IDX_W-1:0];
						rd_idx_q    <= rd_idx_q + CNT_W'(1);
					end else begin
						stat_valid_q <= 1'b1;
						stat_code_q  <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/input_capture_period_collector_core.sv]
// input capture period collector: each command transaction has an accept step, then an execute step
// a status result strobes in the cycle after execution; busy is low again in that cycle
// a run completing on a capture reads the period store, one entry per cycle, so periods
// strobe on consecutive cycles after the readout state and the store's read register, then the ok status
// the receiver cannot stall; reset (arst_n low) clears control state and loads 16 / 100
// into the registers; the period store has no reset, only entries of the current run are read
module input_capture_period_collector_core
	import ipc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// command transaction
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] capture_value,
	input  logic        path_ready,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// result transactions, one per strobe
	output logic        result_strobe,
	output logic        kind,
	output logic [31:0] period_ticks,
	output logic [3:0]  period_slot,
	output logic [2:0]  status,
	output logic        last_item
);

	ipc_cfg_t              cfg_q;
	ipc_ram_req_t          ram_req;
	logic [TICK_WIDTH-1:0] ram_rdata;

	// a write lands in any cycle; a run keeps its own copy latched at start
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_target <= TARGET_RESET;
			cfg_q.timeout_lim   <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PERIOD_TARGET: cfg_q.period_target <= cfg_data[TARGET_W-1:0];
				REG_TIMEOUT:       cfg_q.timeout_lim   <= cfg_data[TIMEOUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer: decodes the command, computes periods, walks the store at run end
	ipc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.capture_value (capture_value),
		.path_ready    (path_ready),
		.cfg           (cfg_q),
		.busy          (busy),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata),
		.result_strobe (result_strobe),
		.kind          (kind),
		.period_ticks  (period_ticks),
		.period_slot   (period_slot),
		.status        (status),
		.last_item     (last_item)
	);

	// period store, written on capture, read during the readout
	ipc_period_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// an accepted command always occupies the execute cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// a period item is always followed by another period or the closing status
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && kind == KIND_PERIOD) |=> result_strobe)
		else $error("readout broke off before the closing status");

	// status items only follow a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && kind == KIND_STATUS) |-> $past(busy))
		else $error("status item without preceding execution");

	// periods come out in store order
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && kind == KIND_PERIOD && period_slot != 4'd0) |->
		($past(result_strobe) && $past(period_slot) == 4'(period_slot - 4'd1)))
		else $error("period readout out of order");

endmodule
